// ----- rtl/spi_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_pkg
// shared types and codes of the sphere path interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

	localparam int DATA_W    = 32;
	localparam int RAD_W     = 31;
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 33;
	localparam int REG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_PATH_KEEP,
		MODE_PATH_RAMP,
		MODE_STEP,
		MODE_READ
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOOP_ENABLE,
		REG_START_RADIUS,
		REG_HOME_X,
		REG_HOME_Y,
		REG_HOME_Z
	} reg_idx_t;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RPT_RD,
		S_RPT_OUT,
		S_PRE_MUL,
		S_PRE_DIV,
		S_PRE_WAIT,
		S_PT_RD,
		S_IP_MUL,
		S_IP_DIV,
		S_IP_WAIT,
		S_SQ_MUL,
		S_SQ_ACC,
		S_RT_START,
		S_RT_WAIT,
		S_PJ_MUL,
		S_PJ_DIV,
		S_PJ_WAIT,
		S_PT_OUT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/spi_iter_unit.sv -----
// ----------------------------------------------------------------------------
// spi_iter_unit
// bit-serial unsigned divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module spi_iter_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire spi_pkg::unit_req_t         req,
	input  wire logic [spi_pkg::NUM_W-1:0]  num,
	input  wire logic [spi_pkg::DEN_W-1:0]  den,
	output logic                            done,
	output logic [spi_pkg::NUM_W-1:0]       res
);

	logic                      busy_q;
	logic                      done_q;
	spi_pkg::unit_op_t         op_q;
	logic [6:0]                cnt_q;
	logic [35:0]               rem_q;
	logic [spi_pkg::NUM_W-1:0] acc_q;
	logic [spi_pkg::NUM_W-1:0] res_q;
	logic [spi_pkg::DEN_W-1:0] den_q;

	logic [35:0] div_rem;
	logic        div_ge;
	logic [35:0] sq_rem;
	logic [35:0] sq_trial;
	logic        sq_ge;

	always_comb begin
		div_rem  = {rem_q[34:0], acc_q[63]};
		div_ge   = div_rem >= {3'b000, den_q};
		sq_rem   = {rem_q[33:0], acc_q[63:62]};
		sq_trial = {res_q[33:0], 2'b01};
		sq_ge    = sq_rem >= sq_trial;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= spi_pkg::OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == spi_pkg::OP_SQRT) ? 7'd31 : 7'd63;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= num;
			den_q <= den;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			if (op_q == spi_pkg::OP_SQRT) begin
				acc_q <= {acc_q[61:0], 2'b00};
				if (sq_ge) begin
					rem_q <= sq_rem - sq_trial;
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= sq_rem;
					res_q <= {res_q[62:0], 1'b0};
				end
			end else begin
				acc_q <= {acc_q[62:0], 1'b0};
				if (div_ge) begin
					rem_q <= div_rem - {3'b000, den_q};
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= div_rem;
					res_q <= {res_q[62:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ----- rtl/sphere_path_interpolator.sv -----
// ----------------------------------------------------------------------------
// sphere_path_interpolator
// linear path interpolation with projection of each point onto a sphere
// ----------------------------------------------------------------------------
//
// channel   direction  bits                         contents
// cfg       in         cfg_index 3, cfg_data 32     register writes, index 0..4
// s_axis    in         tdata 232, tuser 2           path, step or read command
// m_axis    out        tdata 104, tuser 1, tlast    point results
//
// a step or read command reads the point memory, then waits out any output backpressure.
// a path command runs every point through one shared multiplier and one
// bit-serial divide/root unit.
// reset clears all control state; point and radius memories are undefined
// until a path writes them. the input and configuration sides are not ready
// while a command is in work; a stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_path_interpolator #(
	parameter int MAX_STEPS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration write channel
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	// command input
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// from_x, from_y, from_z, to_x, to_y, to_z, target_radius, step_count, pad
	input  wire logic [231:0]  s_tdata,
	// mode
	input  wire logic [1:0]    s_tuser,
	// result output
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// pos_x, pos_y, pos_z, point_index, pad
	output logic [103:0]       m_tdata,
	// done_res
	output logic               m_tuser,
	output logic               m_tlast
);

	localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int CW = $clog2(MAX_STEPS + 1);

	// configuration registers
	logic                 loop_q;
	logic [30:0]          start_radius_q;
	logic signed [31:0]   home_x_q, home_y_q, home_z_q;

	// persistent state
	logic [30:0]          cur_q;
	logic [CW-1:0]        active_q;
	logic [IW-1:0]        play_q;
	logic                 loaded_q;
	logic [CW-1:0]        wr_hi_q;
	logic                 done_q;

	// sequencer
	spi_pkg::state_t      state_q, state_d;
	logic                 ramp_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [1:0]           k_q;

	// per point working registers
	logic signed [32:0]   base_q [4];
	logic signed [32:0]   dv_q   [4];
	logic signed [31:0]   pc_q   [3];
	logic signed [31:0]   ox_q   [3];
	logic [30:0]          rad_q;
	logic [63:0]          s_q;
	logic [31:0]          m_q;
	logic [64:0]          prod_q;

	// memories
	logic [31:0]          ptx_mem [MAX_STEPS];
	logic [31:0]          pty_mem [MAX_STEPS];
	logic [31:0]          ptz_mem [MAX_STEPS];
	logic [30:0]          rad_mem [MAX_STEPS];
	logic [31:0]          rd_x_q, rd_y_q, rd_z_q;
	logic [30:0]          rad_rd_q;

	// output register
	logic                 m_tvalid_q;
	logic [103:0]         m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;

	// shared unit
	spi_pkg::unit_req_t   unit_req;
	logic [63:0]          unit_num;
	logic [32:0]          unit_den;
	logic                 unit_done;
	logic [63:0]          unit_res;

	logic [32:0]          mul_a;
	logic [31:0]          mul_b;
	logic                 slot_free;
	logic                 pt_we;
	logic                 out_load;
	logic                 last_pt;
	logic [1:0]           k_last;
	logic signed [31:0]   pc_sel;
	logic [31:0]          pc_mag;
	logic [32:0]          dv_mag;
	logic signed [34:0]   q_signed;
	logic signed [34:0]   ip_sum;
	logic signed [31:0]   pj_sat;
	logic [CW-1:0]        cnt_in;
	logic [6:0]           step_in;
	spi_pkg::mode_t       mode_in;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	spi_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.num    (unit_num),
		.den    (unit_den),
		.done   (unit_done),
		.res    (unit_res)
	);

	// decode of the incoming command
	always_comb begin
		mode_in = spi_pkg::mode_t'(s_tuser);
		step_in = s_tdata[229:223];
		if (step_in == 7'd0) begin
			cnt_in = CW'(1);
		end else if (int'(step_in) > MAX_STEPS) begin
			cnt_in = CW'(MAX_STEPS);
		end else begin
			cnt_in = CW'(step_in);
		end
	end

	// shared arithmetic helpers
	always_comb begin
		k_last   = ramp_q ? 2'd3 : 2'd2;
		last_pt  = idx_q == (cnt_q - CW'(1));
		pc_sel   = (k_q == 2'd0) ? pc_q[0] : ((k_q == 2'd1) ? pc_q[1] : pc_q[2]);
		pc_mag   = mag32(pc_sel);
		dv_mag   = mag33(dv_q[k_q]);
		// sign of the running quotient follows the dividend's sign
		if (state_q == spi_pkg::S_PJ_WAIT) begin
			q_signed = pc_sel[31] ? -$signed({2'b00, unit_res[32:0]})
			                      :  $signed({2'b00, unit_res[32:0]});
		end else if (state_q == spi_pkg::S_PRE_WAIT) begin
			q_signed = dv_q[3][32] ? -$signed({2'b00, unit_res[32:0]})
			                       :  $signed({2'b00, unit_res[32:0]});
		end else begin
			q_signed = dv_q[k_q][32] ? -$signed({2'b00, unit_res[32:0]})
			                         :  $signed({2'b00, unit_res[32:0]});
		end
		ip_sum = (state_q == spi_pkg::S_PRE_WAIT)
		         ? {{2{base_q[3][32]}}, base_q[3]} + q_signed
		         : {{2{base_q[k_q][32]}}, base_q[k_q]} + q_signed;
		if (q_signed > 35'sd2147483647) begin
			pj_sat = 32'sh7fffffff;
		end else if (q_signed < -35'sd2147483648) begin
			pj_sat = 32'sh80000000;
		end else begin
			pj_sat = q_signed[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spi_pkg::S_IDLE: begin
				if (s_tvalid) begin
					case (mode_in)
						spi_pkg::MODE_STEP, spi_pkg::MODE_READ: state_d = spi_pkg::S_RPT_RD;
						spi_pkg::MODE_PATH_RAMP:                state_d = spi_pkg::S_PRE_MUL;
						default:                                state_d = spi_pkg::S_PT_RD;
					endcase
				end
			end
			spi_pkg::S_RPT_RD:   state_d = spi_pkg::S_RPT_OUT;
			spi_pkg::S_RPT_OUT:  if (slot_free) state_d = spi_pkg::S_IDLE;
			spi_pkg::S_PRE_MUL:  state_d = spi_pkg::S_PRE_DIV;
			spi_pkg::S_PRE_DIV:  state_d = spi_pkg::S_PRE_WAIT;
			spi_pkg::S_PRE_WAIT: if (unit_done) state_d = spi_pkg::S_PT_RD;
			spi_pkg::S_PT_RD:    state_d = spi_pkg::S_IP_MUL;
			spi_pkg::S_IP_MUL:   state_d = spi_pkg::S_IP_DIV;
			spi_pkg::S_IP_DIV:   state_d = spi_pkg::S_IP_WAIT;
			spi_pkg::S_IP_WAIT: begin
				if (unit_done) begin
					state_d = (k_q == k_last) ? spi_pkg::S_SQ_MUL : spi_pkg::S_IP_MUL;
				end
			end
			spi_pkg::S_SQ_MUL:   state_d = spi_pkg::S_SQ_ACC;
			spi_pkg::S_SQ_ACC:   state_d = (k_q == 2'd2) ? spi_pkg::S_RT_START : spi_pkg::S_SQ_MUL;
			spi_pkg::S_RT_START: state_d = spi_pkg::S_RT_WAIT;
			spi_pkg::S_RT_WAIT: begin
				if (unit_done) begin
					state_d = (unit_res[31:0] == 32'd0) ? spi_pkg::S_PT_OUT : spi_pkg::S_PJ_MUL;
				end
			end
			spi_pkg::S_PJ_MUL:   state_d = spi_pkg::S_PJ_DIV;
			spi_pkg::S_PJ_DIV:   state_d = spi_pkg::S_PJ_WAIT;
			spi_pkg::S_PJ_WAIT: begin
				if (unit_done) begin
					state_d = (k_q == 2'd2) ? spi_pkg::S_PT_OUT : spi_pkg::S_PJ_MUL;
				end
			end
			spi_pkg::S_PT_OUT: begin
				if (slot_free) begin
					state_d = last_pt ? spi_pkg::S_IDLE : spi_pkg::S_PT_RD;
				end
			end
			default: state_d = spi_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: handshakes, multiplier operands, unit requests
	always_comb begin
		s_tready  = state_q == spi_pkg::S_IDLE;
		// register writes only between commands
		cfg_ready = state_q == spi_pkg::S_IDLE;
		slot_free = !m_tvalid_q || m_tready;
		pt_we     = (state_q == spi_pkg::S_PT_OUT) && slot_free;
		out_load  = pt_we || ((state_q == spi_pkg::S_RPT_OUT) && slot_free);
		mul_a     = '0;
		mul_b     = '0;
		unit_req  = '{start: 1'b0, op: spi_pkg::OP_DIV};
		unit_num  = prod_q[63:0];
		unit_den  = 33'(cnt_q);
		case (state_q)
			spi_pkg::S_PRE_MUL: begin
				mul_a = mag33(dv_q[3]);
				mul_b = 32'(cnt_q - CW'(1));
			end
			spi_pkg::S_IP_MUL: begin
				mul_a = dv_mag;
				mul_b = 32'(idx_q);
			end
			spi_pkg::S_SQ_MUL: begin
				mul_a = {1'b0, pc_mag};
				mul_b = pc_mag;
			end
			spi_pkg::S_PJ_MUL: begin
				mul_a = {1'b0, pc_mag};
				mul_b = {1'b0, rad_q};
			end
			spi_pkg::S_PRE_DIV, spi_pkg::S_IP_DIV: begin
				unit_req = '{start: 1'b1, op: spi_pkg::OP_DIV};
			end
			spi_pkg::S_RT_START: begin
				unit_req = '{start: 1'b1, op: spi_pkg::OP_SQRT};
				unit_num = s_q;
			end
			spi_pkg::S_PJ_DIV: begin
				unit_req = '{start: 1'b1, op: spi_pkg::OP_DIV};
				unit_den = {1'b0, m_q};
			end
			default: begin
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= spi_pkg::S_IDLE;
			loop_q         <= 1'b0;
			start_radius_q <= 31'd65536;
			home_x_q       <= '0;
			home_y_q       <= '0;
			home_z_q       <= '0;
			cur_q          <= 31'd65536;
			active_q       <= CW'(1);
			play_q         <= '0;
			loaded_q       <= 1'b0;
			wr_hi_q        <= '0;
			done_q         <= 1'b0;
			ramp_q         <= 1'b0;
			cnt_q          <= CW'(1);
			idx_q          <= '0;
			k_q            <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result replaces one that is taken in the same cycle
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (spi_pkg::reg_idx_t'(cfg_index))
					spi_pkg::REG_LOOP_ENABLE: loop_q <= cfg_data[0];
					spi_pkg::REG_START_RADIUS: begin
						start_radius_q <= cfg_data[30:0];
						// no radius entry written yet: current radius follows
						if (wr_hi_q == '0) cur_q <= cfg_data[30:0];
					end
					spi_pkg::REG_HOME_X: home_x_q <= cfg_data;
					spi_pkg::REG_HOME_Y: home_y_q <= cfg_data;
					spi_pkg::REG_HOME_Z: home_z_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				spi_pkg::S_IDLE: begin
					if (s_tvalid) begin
						ramp_q <= mode_in == spi_pkg::MODE_PATH_RAMP;
						cnt_q  <= cnt_in;
						idx_q  <= '0;
						k_q    <= '0;
						done_q <= 1'b0;
						if (mode_in == spi_pkg::MODE_STEP) begin
							if ((CW'(play_q) + CW'(1)) < active_q) begin
								play_q <= play_q + IW'(1);
							end else if (loop_q) begin
								play_q <= '0;
							end else begin
								done_q <= 1'b1;
							end
						end
					end
				end
				spi_pkg::S_PRE_WAIT: begin
					if (unit_done) cur_q <= ip_sum[30:0];
				end
				spi_pkg::S_PT_RD: k_q <= '0;
				spi_pkg::S_IP_WAIT: begin
					if (unit_done) k_q <= (k_q == k_last) ? 2'd0 : k_q + 2'd1;
				end
				spi_pkg::S_SQ_ACC: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				spi_pkg::S_RT_WAIT: begin
					if (unit_done) k_q <= '0;
				end
				spi_pkg::S_PJ_WAIT: begin
					if (unit_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				spi_pkg::S_PT_OUT: begin
					if (slot_free) begin
						if (last_pt) begin
							active_q <= cnt_q;
							play_q   <= '0;
							loaded_q <= 1'b1;
							if (cnt_q > wr_hi_q) wr_hi_q <= cnt_q;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * {1'b0, mul_b};
		case (state_q)
			spi_pkg::S_IDLE: begin
				base_q[0] <= 33'(signed'(s_tdata[31:0]));
				base_q[1] <= 33'(signed'(s_tdata[63:32]));
				base_q[2] <= 33'(signed'(s_tdata[95:64]));
				base_q[3] <= {2'b00, cur_q};
				dv_q[0]   <= 33'(signed'(s_tdata[127:96])) - 33'(signed'(s_tdata[31:0]));
				dv_q[1]   <= 33'(signed'(s_tdata[159:128])) - 33'(signed'(s_tdata[63:32]));
				dv_q[2]   <= 33'(signed'(s_tdata[191:160])) - 33'(signed'(s_tdata[95:64]));
				dv_q[3]   <= {2'b00, s_tdata[222:192]} - {2'b00, cur_q};
			end
			spi_pkg::S_IP_WAIT: begin
				if (unit_done) begin
					if (k_q == 2'd3) begin
						rad_q <= ip_sum[30:0];
					end else if (k_q == 2'd2) begin
						pc_q[2] <= ip_sum[31:0];
					end else if (k_q == 2'd1) begin
						pc_q[1] <= ip_sum[31:0];
					end else begin
						pc_q[0] <= ip_sum[31:0];
					end
					s_q <= '0;
				end
			end
			spi_pkg::S_SQ_ACC: s_q <= s_q + prod_q[63:0];
			spi_pkg::S_RT_START: begin
				// without a ramp, radius comes from the table or the start radius
				if (!ramp_q) rad_q <= (idx_q < wr_hi_q) ? rad_rd_q : start_radius_q;
			end
			spi_pkg::S_RT_WAIT: begin
				if (unit_done) begin
					m_q <= unit_res[31:0];
					ox_q[0] <= '0;
					ox_q[1] <= '0;
					ox_q[2] <= '0;
				end
			end
			spi_pkg::S_PJ_WAIT: begin
				if (unit_done) begin
					if (k_q == 2'd2) begin
						ox_q[2] <= pj_sat;
					end else if (k_q == 2'd1) begin
						ox_q[1] <= pj_sat;
					end else begin
						ox_q[0] <= pj_sat;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// point and radius memories
	always_ff @(posedge clk) begin
		if (pt_we) begin
			ptx_mem[idx_q[IW-1:0]] <= ox_q[0];
			pty_mem[idx_q[IW-1:0]] <= ox_q[1];
			ptz_mem[idx_q[IW-1:0]] <= ox_q[2];
			rad_mem[idx_q[IW-1:0]] <= cur_q;
		end
		rd_x_q   <= ptx_mem[play_q];
		rd_y_q   <= pty_mem[play_q];
		rd_z_q   <= ptz_mem[play_q];
		rad_rd_q <= rad_mem[idx_q[IW-1:0]];
	end

	// output payload register
	always_ff @(posedge clk) begin
		if ((state_q == spi_pkg::S_RPT_OUT) && slot_free) begin
			m_tdata_q <= loaded_q ? {2'b00, 6'(play_q), rd_z_q, rd_y_q, rd_x_q}
			                      : {2'b00, 6'(play_q), home_z_q, home_y_q, home_x_q};
			m_tuser_q <= done_q;
			m_tlast_q <= 1'b1;
		end else if (pt_we) begin
			m_tdata_q <= {2'b00, 6'(idx_q), ox_q[2], ox_q[1], ox_q[0]};
			m_tuser_q <= 1'b0;
			m_tlast_q <= last_pt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// the shared unit only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == spi_pkg::S_PRE_WAIT || state_q == spi_pkg::S_IP_WAIT ||
		               state_q == spi_pkg::S_RT_WAIT || state_q == spi_pkg::S_PJ_WAIT))
		else $error("shared unit finished outside a wait state");

	// playback never points past the loaded path
	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q != '0) && (CW'(play_q) < active_q))
		else $error("playback index beyond active count");

	// a done report is always the single, last result of its command
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> m_tlast_q)
		else $error("done result without last");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sphere path interpolator
// ----------------------------------------------------------------------------
// A table of directed commands and register writes runs first: reads and steps
// before any path, home and radius extremes, zero-length and clamped paths,
// radius ramps and looping. Random phases with fresh register settings follow.
// A built-in predictor models the block and works out every expected point.
// Both stream sides idle at random. The output side holds off once for a long
// stretch, and the input side drains the block before each register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	localparam int          STEPS      = 64;
	localparam int          WDOG_LIMIT = 20000;
	localparam logic [2:0]  REG_UNUSED = 3'd7;

	// one point result as the output side carries it
	typedef struct {
		logic signed [31:0] x, y, z;
		logic [5:0]         idx;
		logic               done, last;
	} point_t;

	typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

	// one row of the directed plan: a command or a register write
	typedef struct {
		row_kind_t          kind;
		spi_pkg::mode_t     mode;
		logic signed [31:0] fx, fy, fz, tx, ty, tz;
		logic [30:0]        trad;
		logic [6:0]         cnt;
		logic [2:0]         ridx;
		logic [31:0]        rval;
		bit                 typed;
		point_t             want;
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [2:0]    cfg_index = '0;
	logic [31:0]   cfg_data = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [231:0]  s_tdata = '0;
	logic [1:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [103:0]  m_tdata;
	logic          m_tuser;
	logic          m_tlast;

	sphere_path_interpolator #(.MAX_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor copy of the block state and its registers
	bit      loop_on;
	longint  start_rad, home_x, home_y, home_z;
	longint  store_x[STEPS], store_y[STEPS], store_z[STEPS], rad_store[STEPS];
	bit      rad_valid[STEPS];
	longint  cur_rad;
	int      active_cnt, play_idx;
	bit      have_path;

	point_t  pending_points[$];
	int      errors;
	bit      no_idle, long_hold_req, long_hold_done;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
		bit any;
		any = 0;
		case (idx)
			spi_pkg::REG_LOOP_ENABLE: loop_on = val[0];
			spi_pkg::REG_START_RADIUS: begin
				start_rad = longint'(val[30:0]);
				foreach (rad_valid[i]) any |= rad_valid[i];
				// radius follows the start value until a path writes one
				if (!any) cur_rad = start_rad;
			end
			spi_pkg::REG_HOME_X: home_x = longint'($signed(val));
			spi_pkg::REG_HOME_Y: home_y = longint'($signed(val));
			spi_pkg::REG_HOME_Z: home_z = longint'($signed(val));
			default: ;
		endcase
	endfunction

	function automatic void push_current(bit done);
		point_t p;
		int i;
		i = play_idx % STEPS;
		if (have_path) begin
			p.x = 32'(store_x[i]); p.y = 32'(store_y[i]); p.z = 32'(store_z[i]);
			p.idx = 6'(i);
		end else begin
			p.x = 32'(home_x); p.y = 32'(home_y); p.z = 32'(home_z);
			p.idx = 6'(play_idx);
		end
		p.done = done;
		p.last = 1'b1;
		pending_points.push_back(p);
	endfunction

	// expected points for one accepted command
	function automatic void predict_points(row_t c);
		int n;
		longint dr, fx, fy, fz, dx, dy, dz, px, py, pz, r, m, ox, oy, oz;
		point_t p;
		bit done;
		done = 0;
		case (c.mode)
			spi_pkg::MODE_STEP: begin
				if (play_idx + 1 < active_cnt) play_idx++;
				else if (loop_on) play_idx = 0;
				else done = 1;
				push_current(done);
			end
			spi_pkg::MODE_READ: push_current(0);
			default: begin
				n = c.cnt;
				if (n < 1) n = 1;
				if (n > STEPS) n = STEPS;
				if (c.mode == spi_pkg::MODE_PATH_RAMP) begin
					dr = longint'(c.trad) - cur_rad;
					for (int i = 0; i < n; i++) begin
						rad_store[i] = cur_rad + (dr * i) / n;
						rad_valid[i] = 1;
					end
					cur_rad = rad_store[n-1];
				end
				fx = c.fx; fy = c.fy; fz = c.fz;
				dx = longint'(c.tx) - fx;
				dy = longint'(c.ty) - fy;
				dz = longint'(c.tz) - fz;
				for (int i = 0; i < n; i++) begin
					px = fx + (dx * i) / n;
					py = fy + (dy * i) / n;
					pz = fz + (dz * i) / n;
					r = rad_valid[i] ? rad_store[i] : start_rad;
					m = longint'(root_floor(absl(px) * absl(px) + absl(py) * absl(py)
						+ absl(pz) * absl(pz)));
					ox = 0; oy = 0; oz = 0;
					// zero-length point stays at the origin
					if (m != 0) begin
						ox = clip32((px * r) / m);
						oy = clip32((py * r) / m);
						oz = clip32((pz * r) / m);
					end
					store_x[i] = ox; store_y[i] = oy; store_z[i] = oz;
					p.x = 32'(ox); p.y = 32'(oy); p.z = 32'(oz); p.idx = 6'(i);
					p.done = 0; p.last = (i + 1 == n);
					pending_points.push_back(p);
				end
				for (int i = 0; i < n; i++) begin
					rad_store[i] = cur_rad;
					rad_valid[i] = 1;
				end
				active_cnt = n;
				play_idx = 0;
				have_path = 1;
			end
		endcase
	endfunction

	function automatic row_t blank_row();
		row_t w;
		w.kind = ROW_CMD; w.mode = spi_pkg::MODE_READ;
		w.fx = '0; w.fy = '0; w.fz = '0; w.tx = '0; w.ty = '0; w.tz = '0;
		w.trad = '0; w.cnt = '0; w.ridx = '0; w.rval = '0; w.typed = 0;
		w.want.x = '0; w.want.y = '0; w.want.z = '0; w.want.idx = '0;
		w.want.done = 1'b0; w.want.last = 1'b0;
		return w;
	endfunction

	function automatic row_t cmd_row(spi_pkg::mode_t md, logic signed [31:0] fx, fy, fz,
			tx, ty, tz, logic [30:0] trad, logic [6:0] cnt);
		row_t w;
		w = blank_row();
		w.kind = ROW_CMD; w.mode = md;
		w.fx = fx; w.fy = fy; w.fz = fz; w.tx = tx; w.ty = ty; w.tz = tz;
		w.trad = trad; w.cnt = cnt;
		return w;
	endfunction

	function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] val);
		row_t w;
		w = blank_row();
		w.kind = ROW_CFG; w.ridx = idx; w.rval = val;
		return w;
	endfunction

	// attach a result that can be read off directly
	function automatic row_t typed_row(row_t w, logic signed [31:0] x, y, z,
			logic [5:0] idx, logic done);
		w.typed = 1;
		w.want.x = x; w.want.y = y; w.want.z = z; w.want.idx = idx;
		w.want.done = done; w.want.last = 1'b1;
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
	endtask

	// command transfer, entered and left at a falling edge
	task automatic send_cmd(row_t c);
		while (!no_idle && $urandom_range(99) < 11) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = c.mode;
		s_tdata = {2'b00, c.cnt, c.trad, c.tz, c.ty, c.tx, c.fz, c.fy, c.fx};
		// ready only moves at a rising edge, so the value seen here holds at the next one
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		predict_points(c);
		if (c.typed) begin
			void'(pending_points.pop_back());
			pending_points.push_back(c.want);
		end
		@(negedge clk);
	endtask

	// register writes only once every expected point has come back
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		s_tvalid = 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord();
		// mostly modest coordinates, some over the full range
		if ($urandom_range(3) == 0) return $urandom;
		return $signed($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000;
	endfunction

	function automatic row_t rand_cmd();
		row_t c;
		int sel;
		logic [6:0] n;
		logic [30:0] tr;
		sel = $urandom_range(99);
		if ($urandom_range(99) < 2) n = 7'($urandom_range(64, 127));
		else if ($urandom_range(9) == 0) n = 7'($urandom_range(9, 20));
		else n = 7'($urandom_range(0, 8));
		tr = ($urandom_range(1) == 0) ? 31'($urandom) : 31'($urandom_range(32'h0004_0000));
		c = cmd_row(sel < 15 ? spi_pkg::MODE_PATH_KEEP : sel < 30 ? spi_pkg::MODE_PATH_RAMP :
			sel < 75 ? spi_pkg::MODE_STEP : spi_pkg::MODE_READ,
			rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), tr, n);
		return c;
	endfunction

	// result side: idles at random, one long hold-off on request
	initial begin
		point_t want;
		logic [5:0] got_idx;
		logic got_valid, got_user, got_last;
		logic [103:0] got_data;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				m_tready = 1'b0;
				repeat (600) @(negedge clk);
				long_hold_done = 1;
			end
			m_tready = no_idle || ($urandom_range(99) >= 11);
			// outputs are registered, so these are the values at the next rising edge
			got_valid = m_tvalid;
			got_data = m_tdata;
			got_user = m_tuser;
			got_last = m_tlast;
			@(posedge clk);
			if (got_valid && m_tready) begin
				if (pending_points.size() == 0) begin
					errors++;
					$display("unexpected point transfer");
				end else begin
					want = pending_points.pop_front();
					got_idx = got_data[101:96];
					if ($signed(got_data[31:0]) !== want.x)
						report_mismatch("pos_x", $signed(got_data[31:0]), want.x);
					if ($signed(got_data[63:32]) !== want.y)
						report_mismatch("pos_y", $signed(got_data[63:32]), want.y);
					if ($signed(got_data[95:64]) !== want.z)
						report_mismatch("pos_z", $signed(got_data[95:64]), want.z);
					if (got_idx !== want.idx)
						report_mismatch("point_index", got_idx, want.idx);
					if (got_user !== want.done)
						report_mismatch("done_res", got_user, want.done);
					if (got_last !== want.last)
						report_mismatch("last", got_last, want.last);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		row_t plan[$];
		logic signed [31:0] q1;
		q1 = 32'sh0001_0000;
		loop_on = 0; start_rad = 65536; home_x = 0; home_y = 0; home_z = 0;
		foreach (rad_valid[i]) rad_valid[i] = 0;
		cur_rad = 65536; active_cnt = 1; play_idx = 0; have_path = 0;
		errors = 0; no_idle = 0; long_hold_req = 0; long_hold_done = 0;

		// reset state first, then homes and radius at their extremes
		plan.push_back(typed_row(cmd_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1),
			0, 0, 0, 0, 0));
		plan.push_back(typed_row(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1),
			0, 0, 0, 0, 1));
		plan.push_back(cfg_row(spi_pkg::REG_START_RADIUS, 32'h7FFF_FFFF));
		plan.push_back(cfg_row(spi_pkg::REG_HOME_X, 32'h7FFF_FFFF));
		plan.push_back(cfg_row(spi_pkg::REG_HOME_Y, 32'h8000_0000));
		plan.push_back(cfg_row(spi_pkg::REG_HOME_Z, 32'hFFFF_FFFF));
		plan.push_back(typed_row(cmd_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1),
			32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0, 0));
		plan.push_back(cfg_row(REG_UNUSED, 32'd123));
		// zero-length path lands on the origin
		plan.push_back(typed_row(cmd_row(spi_pkg::MODE_PATH_KEEP, 0, 0, 0, 5, 5, 5, 0, 1),
			0, 0, 0, 0, 0));
		// count zero clamps up, count above the store clamps down
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_KEEP, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			31'h7FFF_FFFF, 0));
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_KEEP, q1, 2 * q1, 3 * q1, -5 * q1, 4 * q1,
			-q1, 0, 127));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cfg_row(spi_pkg::REG_LOOP_ENABLE, 32'd1));
		// single-point ramp leaves the radius alone
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_RAMP, q1, q1, q1, -q1, -q1, -q1, 0, 1));
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_RAMP, -q1, 0, q1, q1, 0, -q1,
			31'h7FFF_FFFF, 5));
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_RAMP, 3 * q1, q1, 0, 0, -q1, 2 * q1, 0, 3));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cfg_row(spi_pkg::REG_LOOP_ENABLE, 32'd0));
		plan.push_back(cfg_row(spi_pkg::REG_START_RADIUS, 32'd0));
		plan.push_back(cmd_row(spi_pkg::MODE_PATH_KEEP, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 2));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(spi_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG) write_reg(plan[k].ridx, plan[k].rval);
			else send_cmd(plan[k]);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(spi_pkg::REG_LOOP_ENABLE, 32'(ph[0]));
			write_reg(spi_pkg::REG_START_RADIUS, (ph == 3) ? 32'hFFFF_FFFF : $urandom);
			write_reg(spi_pkg::REG_HOME_X, $urandom);
			write_reg(spi_pkg::REG_HOME_Y, $urandom);
			write_reg(spi_pkg::REG_HOME_Z, $urandom);
			no_idle = (ph == 2);
			for (int k = 0; k < 30; k++) begin
				if (ph == 1 && k == 5) long_hold_req = 1;
				send_cmd(rand_cmd());
			end
		end
		no_idle = 0;
		s_tvalid = 1'b0;

		while (pending_points.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/spi_pkg.sv
rtl/spi_iter_unit.sv
rtl/sphere_path_interpolator.sv
tb/tb_top.sv
